>>> hdl/pixel_z_block_write_top_macros.svh
// ---------------------------------------------------------------------------
// pixel_z_block_write_top_macros.svh
// assertion helpers for the depth-tested block write
// ---------------------------------------------------------------------------
`ifndef PIXEL_Z_BLOCK_WRITE_TOP_MACROS_SVH
`define PIXEL_Z_BLOCK_WRITE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PZBW_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PZBW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pzbw_pkg.sv
// ---------------------------------------------------------------------------
// pzbw_pkg
// shared constants for the depth-tested block write
// ---------------------------------------------------------------------------
package pzbw_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int COUNT_BITS_DEF = 10;

  localparam int OFF_BITS      = 25;
  localparam int DATA_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int IN_BITS       = 3 * DATA_BITS;
  localparam int OUT_RAW_BITS  = 2 * OFF_BITS + 2 * DATA_BITS;
  localparam int OUT_BITS      = ((OUT_RAW_BITS + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_Z_MODE       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_SELECT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_START      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_START      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_LENGTH   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT    = 3'd7;

  // depth compare modes
  localparam logic [2:0] ZM_ALWAYS     = 3'd0;
  localparam logic [2:0] ZM_LT         = 3'd1;
  localparam logic [2:0] ZM_EQ         = 3'd2;
  localparam logic [2:0] ZM_LE         = 3'd3;
  localparam logic [2:0] ZM_GT         = 3'd4;
  localparam logic [2:0] ZM_NE         = 3'd5;
  localparam logic [2:0] ZM_GE         = 3'd6;
  localparam logic [2:0] ZM_COLOR_ONLY = 3'd7;

  // pixel type ranges
  localparam logic [3:0] PTYPE_HI_BASE  = 4'd13;
  localparam logic [3:0] PTYPE_MID_BASE = 4'd9;

  // depth plane per pixel type range
  localparam logic [1:0] ZPLANE_HI  = 2'd2;
  localparam logic [1:0] ZPLANE_MID = 2'd3;
  localparam logic [1:0] ZPLANE_LO  = 2'd1;

endpackage

>>> hdl/pixel_z_block_write_top.sv
// ---------------------------------------------------------------------------
// pixel_z_block_write_top
// write side of a depth-tested 2d pixel block transfer
// ---------------------------------------------------------------------------
// usage:
//   s_* takes one pixel per request in raster order: source color, source
//   depth and the depth already stored at the destination. m_* returns one
//   write request per pixel: color and depth plane word offsets, the values
//   to write, write enables in tuser and the window's final pixel on tlast.
//   cfg_* writes the window, plane and depth-compare registers; it is always
//   ready and should only be used while no pixel is in flight.
// timing:
//   an accepted pixel passes the input register and then the result register
//   before it shows on m_*. one pixel per cycle is sustained while m_tready
//   stays high, set by the input register and the result register, with one
//   25-bit multiply and its adds between them. pixels that arrive while the
//   window is empty are taken and dropped.
// reset:
//   rst clears both pipeline stages, the column and row counters and the
//   registers (z_mode returns to color-only).
// stalls:
//   when m_tready is low the result holds, the input stage fills, and
//   s_tready falls only once both stages hold a pixel.
// ---------------------------------------------------------------------------
`include "pixel_z_block_write_top_macros.svh"

module pixel_z_block_write_top
  import pzbw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // pixel input
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_BITS-1:0]       s_tdata,  // source_color, source_depth, stored_depth
  // write request output
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_BITS-1:0]      m_tdata,  // color_offset, depth_offset, color_out,
                                             // depth_out, zero fill
  output logic [1:0]               m_tuser,  // write_color, write_depth
  output logic                     m_tlast   // last_pixel
);

  // configuration registers
  logic [2:0]            z_mode;
  logic [3:0]            plane_select;
  logic [COORD_BITS-1:0] line_width;
  logic [COORD_BITS-1:0] frame_height;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COUNT_BITS-1:0] row_length;
  logic [COUNT_BITS-1:0] row_count;

  // plane size is registered from line width and frame height; config must be
  // quiet long enough for plane_size to update before a pixel reaches the offset stage (not enforced)
  logic [OFF_BITS-1:0]   plane_size;

  // window position counters
  logic [COUNT_BITS-1:0] col_cnt;
  logic [COUNT_BITS-1:0] row_cnt;
  logic [COUNT_BITS-1:0] col_cnt_next;
  logic [COUNT_BITS-1:0] row_cnt_next;

  // input stage
  logic                  s1_valid;
  logic [DATA_BITS-1:0]  s1_color;
  logic [DATA_BITS-1:0]  s1_depth;
  logic [DATA_BITS-1:0]  s1_stored;
  logic [OFF_BITS-1:0]   s1_line;
  logic [OFF_BITS-1:0]   s1_col;
  logic                  s1_last;

  // result stage
  logic                  out_valid;
  logic [OFF_BITS-1:0]   out_coff;
  logic [OFF_BITS-1:0]   out_zoff;
  logic [DATA_BITS-1:0]  out_color;
  logic [DATA_BITS-1:0]  out_depth;
  logic                  out_wc;
  logic                  out_wz;
  logic                  out_last;

  logic                  s_accept;
  logic                  win_empty;
  logic                  end_col;
  logic                  end_row;
  logic                  s1_load;
  logic                  out_load;
  logic                  out_free;

  logic [OFF_BITS-1:0]   pos;
  logic [OFF_BITS-1:0]   coff_next;
  logic [OFF_BITS-1:0]   zoff_next;
  logic [1:0]            cplane;
  logic [1:0]            zplane;
  logic                  skip;

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      z_mode       <= ZM_COLOR_ONLY;
      plane_select <= '0;
      line_width   <= '0;
      frame_height <= '0;
      x_start      <= '0;
      y_start      <= '0;
      row_length   <= '0;
      row_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_Z_MODE:       z_mode       <= cfg_data[2:0];
        REG_PLANE_SELECT: plane_select <= cfg_data[3:0];
        // width is kept to a multiple of eight pixels
        REG_LINE_WIDTH:   line_width   <= {cfg_data[COORD_BITS-1:3], 3'b000};
        REG_FRAME_HEIGHT: frame_height <= cfg_data[COORD_BITS-1:0];
        REG_X_START:      x_start      <= cfg_data[COORD_BITS-1:0];
        REG_Y_START:      y_start      <= cfg_data[COORD_BITS-1:0];
        REG_ROW_LENGTH:   row_length   <= cfg_data[COUNT_BITS-1:0];
        REG_ROW_COUNT:    row_count    <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_size <= '0;
    end else begin
      plane_size <= OFF_BITS'(line_width) * OFF_BITS'(frame_height);
    end
  end

  // ---------------------------------------------------------------------
  // handshake: two-entry pipeline, each stage moves when the next is free
  // ---------------------------------------------------------------------
  assign out_free = !out_valid || m_tready;
  assign out_load = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign s_accept = s_tvalid && s_tready;

  // an empty window swallows the pixel and leaves the counters alone
  assign win_empty = (row_length == '0) || (row_count == '0);
  assign s1_load   = s_accept && !win_empty;

  // a counter at or past its end (window shrunk) wraps like one at its end
  assign end_col = col_cnt >= (row_length - COUNT_BITS'(1));
  assign end_row = row_cnt >= (row_count - COUNT_BITS'(1));

  always_comb begin
    col_cnt_next = col_cnt + COUNT_BITS'(1);
    row_cnt_next = row_cnt;
    if (end_col) begin
      col_cnt_next = '0;
      row_cnt_next = end_row ? '0 : row_cnt + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (s1_load) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // ---------------------------------------------------------------------
  // input stage: capture pixel and window coordinates
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_color  <= s_tdata[DATA_BITS-1:0];
      s1_depth  <= s_tdata[2*DATA_BITS-1:DATA_BITS];
      s1_stored <= s_tdata[3*DATA_BITS-1:2*DATA_BITS];
      s1_line   <= OFF_BITS'(y_start) + OFF_BITS'(row_cnt);
      s1_col    <= OFF_BITS'(x_start) + OFF_BITS'(col_cnt);
      s1_last   <= end_col && end_row;
    end
  end

  // ---------------------------------------------------------------------
  // offset and depth test stage, all offsets kept modulo 2^25
  // ---------------------------------------------------------------------
  always_comb begin
    cplane = 2'd0;
    zplane = ZPLANE_LO;
    if (plane_select >= PTYPE_HI_BASE) begin
      cplane = 2'(plane_select - PTYPE_HI_BASE);
      zplane = ZPLANE_HI;
    end else if (plane_select >= PTYPE_MID_BASE) begin
      cplane = 2'(plane_select - PTYPE_MID_BASE);
      zplane = ZPLANE_MID;
    end
  end

  function automatic logic [OFF_BITS-1:0] plane_base(input logic [OFF_BITS-1:0] psize,
                                                     input logic [1:0] plane);
    logic [OFF_BITS-1:0] base;
    base = '0;
    if (plane[0]) base = psize;
    if (plane[1]) base = base + (psize << 1);
    return base;
  endfunction

  assign pos       = s1_line * OFF_BITS'(line_width) + s1_col;
  assign coff_next = plane_base(plane_size, cplane) + pos;
  assign zoff_next = plane_base(plane_size, zplane) + pos;

  always_comb begin
    case (z_mode)
      ZM_LT:   skip = s1_stored <  s1_depth;
      ZM_EQ:   skip = s1_stored == s1_depth;
      ZM_LE:   skip = s1_stored <= s1_depth;
      ZM_GT:   skip = s1_stored >  s1_depth;
      ZM_NE:   skip = s1_stored != s1_depth;
      ZM_GE:   skip = s1_stored >= s1_depth;
      default: skip = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_coff  <= coff_next;
      out_zoff  <= zoff_next;
      out_color <= s1_color;
      out_depth <= s1_depth;
      out_wc    <= !skip;
      out_wz    <= !skip && (z_mode != ZM_COLOR_ONLY);
      out_last  <= s1_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_BITS'({out_depth, out_color, out_zoff, out_coff});
  assign m_tuser  = {out_wz, out_wc};
  assign m_tlast  = out_last;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `PZBW_ASSERT_NOW(a_color_only_no_depth, m_tvalid && (z_mode == ZM_COLOR_ONLY), !m_tuser[1], "depth write in color-only mode")
  `PZBW_ASSERT_NEXT(a_empty_holds_counters, s_accept && win_empty, $stable(col_cnt) && $stable(row_cnt), "counters moved on empty window")
  `PZBW_ASSERT_NEXT(a_last_wraps, s1_load && end_col && end_row, (col_cnt == '0) && (row_cnt == '0), "counters did not wrap after last pixel")

endmodule

>>> tb/pzbw_write_monitor.sv
// ---------------------------------------------------------------------------
// pzbw_write_monitor
// watches the register, pixel and write request channels of the
// depth-tested block write, predicts every write request and compares it
// ---------------------------------------------------------------------------
module pzbw_write_monitor
  import pzbw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [IN_BITS-1:0]       s_tdata,   // source_color, source_depth, stored_depth
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_BITS-1:0]      m_tdata,   // color_offset, depth_offset, color_out,
                                              // depth_out, zero fill
  input  logic [1:0]               m_tuser,   // write_color, write_depth
  input  logic                     m_tlast,   // last_pixel
  output int                       pending,
  output int                       errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OFF_BITS-1:0]  color_off;
    logic [OFF_BITS-1:0]  depth_off;
    logic [DATA_BITS-1:0] color;
    logic [DATA_BITS-1:0] depth;
    logic                 wr_color;
    logic                 wr_depth;
    logic                 last;
  } write_req_t;

  logic [2:0]  z_mode;
  logic [3:0]  plane_sel;
  logic [10:0] line_width;
  logic [10:0] frame_height;
  logic [10:0] x_start;
  logic [10:0] y_start;
  logic [9:0]  row_length;
  logic [9:0]  row_count;
  logic [9:0]  col_cnt;
  logic [9:0]  row_cnt;

  write_req_t expected_writes[$];
  int         err_cnt = 0;

  function automatic logic depth_blocks(logic [2:0] mode, logic [15:0] stored,
                                        logic [15:0] src);
    case (mode)
      ZM_LT:   return stored < src;
      ZM_EQ:   return stored == src;
      ZM_LE:   return stored <= src;
      ZM_GT:   return stored > src;
      ZM_NE:   return stored != src;
      ZM_GE:   return stored >= src;
      default: return 1'b0;
    endcase
  endfunction

  // one write request per pixel; advances the window counters
  function automatic write_req_t predict_write_request(logic [15:0] color,
                                                       logic [15:0] depth,
                                                       logic [15:0] stored);
    longint unsigned plane_size;
    longint unsigned pos;
    logic [1:0]      cplane;
    logic [1:0]      zplane;
    logic            skip;
    logic            end_col;
    logic            end_row;
    write_req_t      req;
    cplane = 2'd0;
    zplane = ZPLANE_LO;
    if (plane_sel >= PTYPE_HI_BASE) begin
      cplane = 2'(plane_sel - PTYPE_HI_BASE);
      zplane = ZPLANE_HI;
    end else if (plane_sel >= PTYPE_MID_BASE) begin
      cplane = 2'(plane_sel - PTYPE_MID_BASE);
      zplane = ZPLANE_MID;
    end
    plane_size = line_width;
    plane_size = plane_size * frame_height;
    pos = y_start;
    pos = (pos + row_cnt) * line_width + x_start + col_cnt;
    skip    = depth_blocks(z_mode, stored, depth);
    end_col = col_cnt >= row_length - 1;
    end_row = row_cnt >= row_count - 1;

    req.color_off = OFF_BITS'(plane_size * cplane + pos);
    req.depth_off = OFF_BITS'(plane_size * zplane + pos);
    req.color     = color;
    req.depth     = depth;
    req.wr_color  = !skip;
    req.wr_depth  = !skip && (z_mode != ZM_COLOR_ONLY);
    req.last      = end_col && end_row;

    // counters past a shrunk end wrap like at the end
    if (end_col) begin
      col_cnt = '0;
      row_cnt = end_row ? '0 : row_cnt + 10'd1;
    end else begin
      col_cnt = col_cnt + 10'd1;
    end
    return req;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    write_req_t want;
    if (rst) begin
      z_mode       = ZM_COLOR_ONLY;
      plane_sel    = '0;
      line_width   = '0;
      frame_height = '0;
      x_start      = '0;
      y_start      = '0;
      row_length   = '0;
      row_count    = '0;
      col_cnt      = '0;
      row_cnt      = '0;
      expected_writes.delete();
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t ns: unexpected write request, expected none, actual %h",
                   $time, m_tdata);
          err_cnt++;
        end else begin
          want = expected_writes.pop_front();
          compare_field("color_offset", want.color_off, m_tdata[OFF_BITS-1:0]);
          compare_field("depth_offset", want.depth_off, m_tdata[2*OFF_BITS-1:OFF_BITS]);
          compare_field("color_out", want.color,
                        m_tdata[2*OFF_BITS+DATA_BITS-1:2*OFF_BITS]);
          compare_field("depth_out", want.depth,
                        m_tdata[2*OFF_BITS+2*DATA_BITS-1:2*OFF_BITS+DATA_BITS]);
          compare_field("write_color", want.wr_color, m_tuser[0]);
          compare_field("write_depth", want.wr_depth, m_tuser[1]);
          compare_field("last_pixel", want.last, m_tlast);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_Z_MODE:       z_mode       = cfg_data[2:0];
          REG_PLANE_SELECT: plane_sel    = cfg_data[3:0];
          REG_LINE_WIDTH:   line_width   = {cfg_data[10:3], 3'b000};
          REG_FRAME_HEIGHT: frame_height = cfg_data[10:0];
          REG_X_START:      x_start      = cfg_data[10:0];
          REG_Y_START:      y_start      = cfg_data[10:0];
          REG_ROW_LENGTH:   row_length   = cfg_data[9:0];
          REG_ROW_COUNT:    row_count    = cfg_data[9:0];
          default: ;
        endcase
      end

      // empty window: pixel is dropped, counters hold
      if (s_tvalid && s_tready && row_length != 0 && row_count != 0)
        expected_writes.push_back(predict_write_request(
          s_tdata[DATA_BITS-1:0], s_tdata[2*DATA_BITS-1:DATA_BITS],
          s_tdata[3*DATA_BITS-1:2*DATA_BITS]));

      pending <= expected_writes.size();
    end
    errors <= err_cnt;
  end

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the depth-tested block write: directed corner
// pixels, then random windows and pixels under shifting back-pressure
// ---------------------------------------------------------------------------
module tb_top
  import pzbw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 4;      // result passes the input and result registers after the request
  localparam int HOLD_CYCLES  = 200;    // long receiver hold-off to fill the pipe
  localparam int ITEM_TARGET  = 650;    // random pixels inside live windows

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  logic [IN_BITS-1:0]       s_tdata   = '0;   // source_color, source_depth, stored_depth
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  logic [OUT_BITS-1:0]      m_tdata;          // color_offset, depth_offset, color_out,
                                              // depth_out, zero fill
  logic [1:0]               m_tuser;          // write_color, write_depth
  logic                     m_tlast;          // last_pixel

  int pending;
  int errors;

  // back-pressure knobs, percent of cycles spent idle
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_armed  = 1'b0;
  bit hold_done   = 1'b0;
  int hold_cnt    = 0;

  pixel_z_block_write_top i_dut (.*);

  pzbw_write_monitor i_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case a request hangs
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random ready, with one long hold-off once armed
  always @(posedge clk) begin
    if (hold_armed && !hold_done) begin
      m_tready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES - 1)
        hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // register write; valid stays up so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
  endtask

  // one pixel request, preceded by random sender gaps
  task automatic push_pixel(input logic [15:0] color, input logic [15:0] depth,
                            input logic [15:0] stored);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stored, depth, color};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering pixels and let every request in flight drain out,
  // including dropped pixels that leave no trace in the monitor
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sometimes set bits the register ignores
  function automatic logic [15:0] junk(logic [15:0] val, logic [15:0] keep);
    return ($urandom_range(3) == 0) ? (val | (16'($urandom) & ~keep)) : val;
  endfunction

  function automatic logic [15:0] coord(bit corner);
    return corner ? 16'($urandom_range(1) * 2047) : 16'($urandom_range(2047));
  endfunction

  task automatic random_window(input bit corner, input bit empty);
    int rl;
    int rc;
    // mostly small windows so many frames complete
    rl = corner ? ($urandom_range(1) ? 1023 : 1) : $urandom_range(1, 12);
    rc = corner ? ($urandom_range(1) ? 1023 : 1) : $urandom_range(1, 6);
    if (empty) begin
      if ($urandom_range(1)) rl = 0;
      else rc = 0;
    end
    write_reg(REG_Z_MODE,       junk(16'($urandom_range(7)), 16'h0007));
    write_reg(REG_PLANE_SELECT, junk(16'($urandom_range(15)), 16'h000F));
    write_reg(REG_LINE_WIDTH,   junk(coord(corner), 16'h07FF));
    write_reg(REG_FRAME_HEIGHT, junk(coord(corner), 16'h07FF));
    write_reg(REG_X_START,      junk(coord(corner), 16'h07FF));
    write_reg(REG_Y_START,      junk(coord(corner), 16'h07FF));
    write_reg(REG_ROW_LENGTH,   junk(16'(rl), 16'h03FF));
    write_reg(REG_ROW_COUNT,    junk(16'(rc), 16'h03FF));
    close_cfg();
  endtask

  task automatic random_pixel();
    logic [15:0] color;
    logic [15:0] depth;
    logic [15:0] stored;
    color = 16'($urandom);
    depth = 16'($urandom);
    // bias the stored depth around the source depth to hit every compare
    case ($urandom_range(3))
      0:       stored = depth;
      1:       stored = depth + 16'd1;
      2:       stored = depth - 16'd1;
      default: stored = 16'($urandom);
    endcase
    push_pixel(color, depth, stored);
  endtask

  initial begin
    int  phase;
    int  n;
    int  live;
    bit  empty;
    live = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // window is empty right after reset: pixel is dropped
    push_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
    quiesce();

    // far corner of the largest frame, top pixel type; line width ignores low bits
    write_reg(REG_Z_MODE,       16'(ZM_ALWAYS));
    write_reg(REG_PLANE_SELECT, 16'd15);
    write_reg(REG_LINE_WIDTH,   16'hFFFF);
    write_reg(REG_FRAME_HEIGHT, 16'd2047);
    write_reg(REG_X_START,      16'd2047);
    write_reg(REG_Y_START,      16'd2047);
    write_reg(REG_ROW_LENGTH,   16'd4);
    write_reg(REG_ROW_COUNT,    16'd3);
    close_cfg();
    push_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
    push_pixel(16'h0000, 16'hFFFF, 16'h0000);
    quiesce();

    // shrink the window under the running column counter
    write_reg(REG_ROW_LENGTH, 16'd2);
    write_reg(REG_ROW_COUNT,  16'd1);
    close_cfg();

    // every depth compare, each against stored below, equal and above
    for (int m = ZM_LT; m <= ZM_GE; m++) begin
      quiesce();
      write_reg(REG_Z_MODE,       16'(m));
      write_reg(REG_PLANE_SELECT, 16'(PTYPE_MID_BASE + m - 1));
      close_cfg();
      push_pixel(16'h1234, 16'h8000, 16'h7FFF);
      push_pixel(16'hEDCB, 16'h8000, 16'h8000);
      push_pixel(16'h5A5A, 16'h8000, 16'h8001);
    end

    // color only: depth offset still computed, no depth write
    quiesce();
    write_reg(REG_Z_MODE,       16'(ZM_COLOR_ONLY));
    write_reg(REG_PLANE_SELECT, 16'd0);
    close_cfg();
    push_pixel(16'hA5A5, 16'h0001, 16'h0001);

    // --- random part, three back-pressure phases ---
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 14; rx_idle_pct = 73; end
        1: begin tx_idle_pct = 73; rx_idle_pct = 14; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      while (live < (phase + 1) * ITEM_TARGET / 3) begin
        quiesce();
        empty = ($urandom_range(11) == 0);
        random_window($urandom_range(3) == 0, empty);
        // receiver stalls for a long stretch while pixels keep coming
        if (phase == 2)
          hold_armed = 1'b1;
        n = empty ? 4 : $urandom_range(45, 65);
        repeat (n) random_pixel();
        if (!empty)
          live += n;
      end
    end

    quiesce();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
